@@ hdl/pbs_pkg.sv @@
// Shared types, constants and state codes of the proportional bandwidth sharer.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none
package pbs_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned RateBitsDef   = 16;
  localparam int unsigned FieldW        = 16;
  localparam int unsigned CountW        = 5;
  localparam logic [15:0] CapReset      = 16'd1600;
  localparam logic [4:0]  LimitReset    = 5'd10;
  localparam logic [15:0] FirstId       = 16'd1;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_LINK_CAPACITY = 1'b0,
    CFG_SESSION_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REFUSE = 2'd1,
    KIND_REPORT = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ADD,
    B_SCAN_RD,
    B_SCAN_CHK,
    B_SUM_DONE,
    B_GR_RD,
    B_GR_MUL,
    B_GR_DIV,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] request_rate;
    logic [15:0] session_minutes;
  } item_t;

endpackage
`default_nettype wire

@@ hdl/pbs_if.sv @@
// Valid/ready channels for input words and result words.
// Depends on pbs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pbs_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [pbs_pkg::FieldW-1:0] request_rate;
  logic [pbs_pkg::FieldW-1:0] session_minutes;
  modport source (output valid, cmd, request_rate, session_minutes, input ready);
  modport sink   (input valid, cmd, request_rate, session_minutes, output ready);
endinterface

interface pbs_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 result_kind;
  logic [pbs_pkg::FieldW-1:0] session_id;
  logic [pbs_pkg::FieldW-1:0] granted_rate;
  logic [pbs_pkg::FieldW-1:0] minutes_left;
  logic [pbs_pkg::CountW-1:0] active_count;
  logic                       last;
  modport source (output valid, result_kind, session_id, granted_rate, minutes_left,
                  active_count, last, input ready);
  modport sink   (input valid, result_kind, session_id, granted_rate, minutes_left,
                  active_count, last, output ready);
endinterface
`default_nettype wire

@@ hdl/pbs_front.sv @@
// Front stage: takes input words, decodes the command and holds one word
// for the queue. Depends on pbs_pkg and pbs_if.
`timescale 1ns / 1ps
`default_nettype none
module pbs_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  pbs_in_if.sink               in_s,
  output logic                 push_o,
  output pbs_pkg::item_t       push_item_o,
  input  wire                  push_ready_i
);
  logic           hold_valid_q, hold_valid_d;
  pbs_pkg::item_t hold_q;

  assign in_s.ready  = !hold_valid_q || push_ready_i;
  assign push_o      = hold_valid_q;
  assign push_item_o = hold_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_s.ready) hold_valid_d = in_s.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  // drop add payload on a tick so the back end sees a clean word
  always_ff @(posedge clk_i) begin
    if (in_s.ready && in_s.valid) begin
      hold_q.cmd <= in_s.cmd ? pbs_pkg::CMD_TICK : pbs_pkg::CMD_ADD;
      hold_q.request_rate    <= in_s.cmd ? '0 : in_s.request_rate;
      hold_q.session_minutes <= in_s.cmd ? '0 : in_s.session_minutes;
    end
  end
endmodule
`default_nettype wire

@@ hdl/pbs_queue.sv @@
// Two-entry queue between front and back stages.
// Depends on pbs_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none
module pbs_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  pbs_pkg::item_t  push_item_i,
  output logic            push_ready_o,
  input  wire             pop_i,
  output logic            pop_valid_o,
  output pbs_pkg::item_t  pop_item_o
);
  pbs_pkg::item_t slot_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = slot_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_item_i;
  end
endmodule
`default_nettype wire

@@ hdl/pbs_back.sv @@
// Back stage: session table memory, tick compaction with demand sum,
// multiply and bit-serial divide for grants, result register.
// Depends on pbs_pkg and pbs_if.
`timescale 1ns / 1ps
`default_nettype none
module pbs_back #(
  parameter int unsigned TABLE_DEPTH = pbs_pkg::TableDepthDef,
  parameter int unsigned RATE_BITS   = pbs_pkg::RateBitsDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire              cfg_idx_i,
  input  wire [15:0]       cfg_data_i,
  input  wire              pop_valid_i,
  input  pbs_pkg::item_t   pop_item_i,
  output logic             pop_o,
  pbs_out_if.source        out_m
);
  localparam int unsigned OW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned DW   = RATE_BITS + OW;
  localparam int unsigned CMPW = (DW > 16) ? DW : 16;
  localparam int unsigned PW   = RATE_BITS + 16;
  localparam int unsigned QCW  = $clog2(PW + 1);

  logic [15:0]          id_mem   [TABLE_DEPTH];
  logic [RATE_BITS-1:0] rate_mem [TABLE_DEPTH];
  logic [15:0]          time_mem [TABLE_DEPTH];

  pbs_pkg::back_state_e state_q, state_d;
  logic [15:0]          cap_q;
  logic [4:0]           limit_q;
  logic [OW-1:0]        occ_q, occ_d, idx_q, idx_d, kept_q, kept_d;
  logic [15:0]          nid_q, nid_d;
  logic [DW-1:0]        demand_q, demand_d;
  logic [PW-1:0]        prod_q, prod_d, quo_q, quo_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [QCW-1:0]       cnt_q, cnt_d;
  logic [RATE_BITS-1:0] grant_q, grant_d;
  pbs_pkg::item_t       item_q, item_d;

  logic [15:0]          id_rd_q, time_rd_q;
  logic [RATE_BITS-1:0] rate_rd_q;

  logic                 we;
  logic [AW-1:0]        wa;
  logic [15:0]          w_id, w_time;
  logic [RATE_BITS-1:0] w_rate;

  logic                 ov_q, ov_d, emit;
  logic [1:0]           kind_q, kind_d;
  logic [15:0]          oid_q, oid_d, ogr_q, ogr_d, omin_q, omin_d;
  logic [4:0]           ocnt_q, ocnt_d;
  logic                 olast_q, olast_d;

  logic                 out_free, full, fits, last_one;
  logic [7:0]           limit_eff;
  logic [DW:0]          rem_sh;

  assign out_m.valid        = ov_q;
  assign out_m.result_kind  = kind_q;
  assign out_m.session_id   = oid_q;
  assign out_m.granted_rate = ogr_q;
  assign out_m.minutes_left = omin_q;
  assign out_m.active_count = ocnt_q;
  assign out_m.last         = olast_q;

  assign out_free  = !ov_q || out_m.ready;
  assign limit_eff = ({3'd0, limit_q} > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH) : {3'd0, limit_q};
  assign full      = (8'(occ_q) >= limit_eff);
  assign fits      = (CMPW'(demand_q) <= CMPW'(cap_q));
  assign last_one  = ((idx_q + 1'b1) == occ_q);
  assign rem_sh    = {rem_q, prod_q[PW-1]};

  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    idx_d    = idx_q;
    kept_d   = kept_q;
    nid_d    = nid_q;
    demand_d = demand_q;
    prod_d   = prod_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    grant_d  = grant_q;
    item_d   = item_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    wa       = occ_q[AW-1:0];
    w_id     = nid_q;
    w_rate   = RATE_BITS'(item_q.request_rate);
    w_time   = item_q.session_minutes;
    emit     = 1'b0;
    kind_d   = kind_q;
    oid_d    = oid_q;
    ogr_d    = ogr_q;
    omin_d   = omin_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;

    unique case (state_q)
      pbs_pkg::B_IDLE: begin
        if (pop_valid_i) begin
          pop_o  = 1'b1;
          item_d = pop_item_i;
          idx_d  = '0;
          kept_d = '0;
          demand_d = '0;
          state_d = (pop_item_i.cmd == pbs_pkg::CMD_TICK) ? pbs_pkg::B_SCAN_RD
                                                           : pbs_pkg::B_ADD;
        end
      end
      pbs_pkg::B_ADD: begin
        if (out_free) begin
          emit    = 1'b1;
          olast_d = 1'b1;
          ogr_d   = '0;
          if (full) begin
            kind_d = pbs_pkg::KIND_REFUSE;
            oid_d  = '0;
            omin_d = '0;
            ocnt_d = 5'(occ_q);
          end else begin
            we     = 1'b1;
            kind_d = pbs_pkg::KIND_ACCEPT;
            oid_d  = nid_q;
            omin_d = item_q.session_minutes;
            ocnt_d = 5'(occ_q + 1'b1);
            occ_d  = occ_q + 1'b1;
            nid_d  = nid_q + 16'd1;
          end
          state_d = pbs_pkg::B_IDLE;
        end
      end
      pbs_pkg::B_SCAN_RD: begin
        if (idx_q == occ_q) begin
          occ_d   = kept_q;
          state_d = pbs_pkg::B_SUM_DONE;
        end else begin
          state_d = pbs_pkg::B_SCAN_CHK;
        end
      end
      pbs_pkg::B_SCAN_CHK: begin
        // keep survivors in order; kept never passes the read index
        if (time_rd_q > 16'd1) begin
          we       = 1'b1;
          wa       = kept_q[AW-1:0];
          w_id     = id_rd_q;
          w_rate   = rate_rd_q;
          w_time   = time_rd_q - 16'd1;
          demand_d = demand_q + DW'(rate_rd_q);
          kept_d   = kept_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = pbs_pkg::B_SCAN_RD;
      end
      pbs_pkg::B_SUM_DONE: begin
        if (occ_q == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            kind_d  = pbs_pkg::KIND_EMPTY;
            oid_d   = '0;
            ogr_d   = '0;
            omin_d  = '0;
            ocnt_d  = '0;
            olast_d = 1'b1;
            state_d = pbs_pkg::B_IDLE;
          end
        end else begin
          idx_d   = '0;
          state_d = pbs_pkg::B_GR_RD;
        end
      end
      pbs_pkg::B_GR_RD: state_d = pbs_pkg::B_GR_MUL;
      pbs_pkg::B_GR_MUL: begin
        if (fits) begin
          grant_d = rate_rd_q;
          state_d = pbs_pkg::B_EMIT;
        end else begin
          prod_d  = PW'(rate_rd_q) * PW'(cap_q);
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = QCW'(PW);
          state_d = pbs_pkg::B_GR_DIV;
        end
      end
      pbs_pkg::B_GR_DIV: begin
        // one quotient bit a cycle, restoring
        if (cnt_q == '0) begin
          grant_d = quo_q[RATE_BITS-1:0];
          state_d = pbs_pkg::B_EMIT;
        end else begin
          prod_d = prod_q << 1;
          if (rem_sh >= {1'b0, demand_q}) begin
            rem_d = DW'(rem_sh - {1'b0, demand_q});
            quo_d = {quo_q[PW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[DW-1:0];
            quo_d = {quo_q[PW-2:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
        end
      end
      pbs_pkg::B_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = pbs_pkg::KIND_REPORT;
          oid_d   = id_rd_q;
          ogr_d   = 16'(grant_q);
          omin_d  = time_rd_q;
          ocnt_d  = 5'(occ_q);
          olast_d = last_one;
          idx_d   = idx_q + 1'b1;
          state_d = last_one ? pbs_pkg::B_IDLE : pbs_pkg::B_GR_RD;
        end
      end
      default: state_d = pbs_pkg::B_IDLE;
    endcase

    ov_d = emit ? 1'b1 : (out_m.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pbs_pkg::B_IDLE;
      cap_q    <= pbs_pkg::CapReset;
      limit_q  <= pbs_pkg::LimitReset;
      occ_q    <= '0;
      nid_q    <= pbs_pkg::FirstId;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      nid_q   <= nid_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pbs_pkg::CFG_LINK_CAPACITY: cap_q   <= cfg_data_i;
          pbs_pkg::CFG_SESSION_LIMIT: limit_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    kept_q   <= kept_d;
    demand_q <= demand_d;
    prod_q   <= prod_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    grant_q  <= grant_d;
    item_q   <= item_d;
    kind_q   <= kind_d;
    oid_q    <= oid_d;
    ogr_q    <= ogr_d;
    omin_q   <= omin_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      id_mem[wa]   <= w_id;
      rate_mem[wa] <= w_rate;
      time_mem[wa] <= w_time;
    end
  end

  always_ff @(posedge clk_i) begin
    id_rd_q   <= id_mem[idx_q[AW-1:0]];
    rate_rd_q <= rate_mem[idx_q[AW-1:0]];
    time_rd_q <= time_mem[idx_q[AW-1:0]];
  end
endmodule
`default_nettype wire

@@ hdl/proportional_bandwidth_sharer_top.sv @@
// Sequencing: an add is taken from the queue in idle and answered from the add state;
// a tick compacts the table with a read and a check state per entry, then per survivor
// reads, multiplies and emits, with a bit-serial divide when demand exceeds the link.
// Throughput: one word in the back end at a time; the front register and the
// queue hold three more.
// Reset: table empty, next id 1, link_capacity 1600, session_limit 10.
`timescale 1ns / 1ps
`default_nettype none
module proportional_bandwidth_sharer_top #(
  parameter int unsigned TABLE_DEPTH = pbs_pkg::TableDepthDef,
  parameter int unsigned RATE_BITS   = pbs_pkg::RateBitsDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire          cfg_idx_i,
  input  wire [15:0]   cfg_data_i,
  pbs_in_if.sink       in_i,
  pbs_out_if.source    out_o
);
  logic           push, push_ready, pop, pop_valid;
  pbs_pkg::item_t push_item, pop_item;

  pbs_front u_front (
    .clk_i, .rst_ni, .in_s(in_i), .push_o(push), .push_item_o(push_item),
    .push_ready_i(push_ready)
  );

  pbs_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_item_i(push_item),
    .push_ready_o(push_ready), .pop_i(pop), .pop_valid_o(pop_valid),
    .pop_item_o(pop_item)
  );

  pbs_back #(.TABLE_DEPTH(TABLE_DEPTH), .RATE_BITS(RATE_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pop_valid_i(pop_valid), .pop_item_i(pop_item), .pop_o(pop), .out_m(out_o)
  );

`ifndef NO_ASSERTIONS
  a_empty_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == pbs_pkg::KIND_EMPTY
      |-> out_o.last && out_o.active_count == '0)
    else $error("empty result not final or count nonzero");
  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.result_kind == pbs_pkg::KIND_ACCEPT ||
                    out_o.result_kind == pbs_pkg::KIND_REFUSE) |-> out_o.last)
    else $error("add status not final");
  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == pbs_pkg::KIND_ACCEPT
      |-> out_o.active_count != '0 && out_o.granted_rate == '0)
    else $error("accepted add with empty table or grant");
  a_report_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == pbs_pkg::KIND_REPORT
      |-> out_o.active_count != '0 && out_o.minutes_left != '0)
    else $error("report from empty table or expired session");
`endif
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for proportional_bandwidth_sharer_top: drives add and tick
// words, predicts session grants internally, checks every result word.
// Depends on pbs_pkg, pbs_if and the block's RTL.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    pbs_pkg::kind_e kind;
    logic [15:0]    id;
    logic [15:0]    grant;
    logic [15:0]    mins;
    logic [4:0]     count;
    logic           last;
  } report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  bit          stall_en;

  pbs_in_if  in_if ();
  pbs_out_if out_if ();

  proportional_bandwidth_sharer_top uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if.sink),
    .out_o     (out_if.source)
  );

  // Predictor state
  logic [15:0] sess_id   [16];
  logic [15:0] sess_rate [16];
  logic [15:0] sess_mins [16];
  int unsigned sess_cnt;
  logic [15:0] next_id;
  logic [15:0] link_cap;
  logic [4:0]  sess_limit;
  report_t     pending_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("** proportional_bandwidth_sharer_top: FAILED **");
      $finish;
    end
  end

  // Receiver stall pattern: stretches of random stalls alternate with free-running stretches
  int unsigned stall_phase;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (!stall_en) out_if.ready <= 1'b1;
    else if (stall_phase[7]) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    report_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word kind=%0d", out_if.result_kind);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_if.result_kind !== exp_r.kind) begin
          $error("result_kind exp %0d got %0d", exp_r.kind, out_if.result_kind); err_cnt++;
        end
        if (out_if.session_id !== exp_r.id) begin
          $error("session_id exp %0d got %0d", exp_r.id, out_if.session_id); err_cnt++;
        end
        if (out_if.granted_rate !== exp_r.grant) begin
          $error("granted_rate exp %0d got %0d", exp_r.grant, out_if.granted_rate);
          err_cnt++;
        end
        if (out_if.minutes_left !== exp_r.mins) begin
          $error("minutes_left exp %0d got %0d", exp_r.mins, out_if.minutes_left); err_cnt++;
        end
        if (out_if.active_count !== exp_r.count) begin
          $error("active_count exp %0d got %0d", exp_r.count, out_if.active_count);
          err_cnt++;
        end
        if (out_if.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_if.last); err_cnt++;
        end
      end
    end
  end

  function automatic void predict_word(pbs_pkg::cmd_e cmd, logic [15:0] rate,
                                       logic [15:0] mins);
    int unsigned lim;
    int unsigned kept;
    longint unsigned demand;
    report_t r;
    lim = (sess_limit < 16) ? sess_limit : 16;
    if (cmd == pbs_pkg::CMD_ADD) begin
      if (sess_cnt >= lim) begin
        r = '{pbs_pkg::KIND_REFUSE, 16'd0, 16'd0, 16'd0, 5'(sess_cnt), 1'b1};
      end else begin
        sess_id[sess_cnt]   = next_id;
        sess_rate[sess_cnt] = rate;
        sess_mins[sess_cnt] = mins;
        sess_cnt++;
        r = '{pbs_pkg::KIND_ACCEPT, next_id, 16'd0, mins, 5'(sess_cnt), 1'b1};
        next_id = next_id + 16'd1;
      end
      pending_q.push_back(r);
      return;
    end
    // Tick: count down and compact in order
    kept = 0;
    for (int i = 0; i < sess_cnt; i++) begin
      if (sess_mins[i] > 1) begin
        sess_id[kept]   = sess_id[i];
        sess_rate[kept] = sess_rate[i];
        sess_mins[kept] = sess_mins[i] - 16'd1;
        kept++;
      end
    end
    sess_cnt = kept;
    if (kept == 0) begin
      pending_q.push_back('{pbs_pkg::KIND_EMPTY, 16'd0, 16'd0, 16'd0, 5'd0, 1'b1});
      return;
    end
    demand = 0;
    for (int i = 0; i < kept; i++) demand += sess_rate[i];
    for (int i = 0; i < kept; i++) begin
      r.kind  = pbs_pkg::KIND_REPORT;
      r.id    = sess_id[i];
      r.grant = (demand <= link_cap) ? sess_rate[i]
              : 16'((64'(sess_rate[i]) * 64'(link_cap)) / demand);
      r.mins  = sess_mins[i];
      r.count = 5'(kept);
      r.last  = (i + 1 == kept);
      pending_q.push_back(r);
    end
  endfunction

  // Send one word; valid stays high across back-to-back words of a burst
  int unsigned burst_left;
  task automatic send_word(pbs_pkg::cmd_e cmd, logic [15:0] rate, logic [15:0] mins);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_if.valid           <= 1'b1;
    in_if.cmd             <= cmd;
    in_if.request_rate    <= rate;
    in_if.session_minutes <= mins;
    do @(posedge clk_i); while (!in_if.ready);
    predict_word(cmd, rate, mins);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // a tick with an empty table still walks the back end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(pbs_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == pbs_pkg::CFG_LINK_CAPACITY) link_cap = val;
    else sess_limit = val[4:0];
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    // reset config: adds with edge-case rates and minutes, ticks, then fill up to the limit
    send_word(pbs_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF);
    send_word(pbs_pkg::CMD_ADD, 16'd0, 16'd0);
    send_word(pbs_pkg::CMD_ADD, 16'd100, 16'd1);
    send_word(pbs_pkg::CMD_ADD, 16'd800, 16'd2);
    send_word(pbs_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
    send_word(pbs_pkg::CMD_TICK, 16'd0, 16'd0);
    for (int i = 0; i < 9; i++) send_word(pbs_pkg::CMD_ADD, 16'(i * 37), 16'(i + 1));
    send_word(pbs_pkg::CMD_TICK, 16'd0, 16'd0);
    send_word(pbs_pkg::CMD_TICK, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_limits();
    write_cfg(pbs_pkg::CFG_SESSION_LIMIT, 16'd0);
    write_cfg(pbs_pkg::CFG_LINK_CAPACITY, 16'd0);
    send_word(pbs_pkg::CMD_ADD, 16'd5, 16'd5);
    drain();
    write_cfg(pbs_pkg::CFG_SESSION_LIMIT, 16'd31);
    for (int i = 0; i < 17; i++)
      send_word(pbs_pkg::CMD_ADD, 16'($urandom), 16'($urandom_range(2, 9)));
    send_word(pbs_pkg::CMD_TICK, 16'd0, 16'd0);
    drain();
    write_cfg(pbs_pkg::CFG_LINK_CAPACITY, 16'hFFFF);
    write_cfg(pbs_pkg::CFG_SESSION_LIMIT, 16'd16);
    send_word(pbs_pkg::CMD_TICK, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned sel;
    logic [15:0] rate;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 3);
      rate = (sel == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      if ($urandom_range(0, 2) == 0)
        send_word(pbs_pkg::CMD_TICK, 16'($urandom), 16'($urandom));
      else
        send_word(pbs_pkg::CMD_ADD, rate,
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    in_if.valid = 1'b0; in_if.cmd = 1'b0;
    in_if.request_rate = '0; in_if.session_minutes = '0;
    out_if.ready = 1'b0;
    cycle_cnt = 0; err_cnt = 0; stall_en = 1'b0; stall_phase = 0; burst_left = 0;
    sess_cnt = 0; next_id = pbs_pkg::FirstId; link_cap = pbs_pkg::CapReset;
    sess_limit = pbs_pkg::LimitReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    stall_en = 1'b1;
    test_limits();
    write_cfg(pbs_pkg::CFG_LINK_CAPACITY, 16'd1600);
    write_cfg(pbs_pkg::CFG_SESSION_LIMIT, 16'd12);
    test_random(30);
    write_cfg(pbs_pkg::CFG_LINK_CAPACITY, 16'd300);
    write_cfg(pbs_pkg::CFG_SESSION_LIMIT, 16'd1);
    test_random(10);
    write_cfg(pbs_pkg::CFG_SESSION_LIMIT, 16'd16);
    test_random(25);
    if (err_cnt == 0) $display("** proportional_bandwidth_sharer_top: PASSED **");
    else $display("** proportional_bandwidth_sharer_top: FAILED **");
    $finish;
  end
endmodule
